>>> hw/rtl/apfp_pkg.sv
// Shared types and constants for the ASCII position frame parser.
// Used by every module under hw/rtl; depends on nothing else.
package apfp_pkg;

  localparam int unsigned FRAME_BYTES_DEF     = 32;
  localparam int unsigned MAX_DIGIT_VALUE_DEF = 99999;

  localparam int unsigned POS_W   = 21;
  localparam int unsigned TIMER_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd100;

  // Request kinds.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic                operation;
    logic [7:0]          rx_byte;
    logic [TIMER_W-1:0]  elapsed_ms;
  } apfp_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    position_valid;
    logic                    frame_accepted;
  } apfp_out_t;

  // Completed good frame, from the parser to the hold logic.
  typedef struct packed {
    logic                    good;
    logic signed [POS_W-1:0] position;
  } apfp_evt_t;

endpackage

>>> hw/rtl/ascii_position_frame_parser_unit.sv
// Top level of the ASCII position frame parser: input register, parser,
// hold logic and output register. Depends on apfp_pkg, apfp_parser, apfp_hold.
// A request is held in the input register, and its result in the output register.
// Throughput: one request per cycle while out_stall is low; both sides are registered, so the
// input register and the output register each hold one request.
// Reset (synchronous, rst_n low) empties both registers, clears the frame
// state, position, valid flag and timer, and loads a 100 ms timeout.
module ascii_position_frame_parser_unit
  import apfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES     = FRAME_BYTES_DEF,
  parameter int unsigned MAX_DIGIT_VALUE = MAX_DIGIT_VALUE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [TIMER_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  apfp_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output apfp_out_t          out_data
);

  logic      in_valid_r;
  apfp_in_t  in_data_r;
  logic      out_valid_r;
  apfp_out_t out_data_r;

  logic      stage_fire;
  logic      in_accept;
  apfp_evt_t evt;
  logic signed [POS_W-1:0] position_nxt;
  logic      valid_nxt;

  // A request moves out of the input register whenever the output register
  // is free or being emptied in the same cycle.
  assign stage_fire = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall   = in_valid_r && out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;

  apfp_parser #(
    .FRAME_BYTES    (FRAME_BYTES),
    .MAX_DIGIT_VALUE(MAX_DIGIT_VALUE)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_fire(stage_fire && (in_data_r.operation == OP_BYTE)),
    .rx_byte  (in_data_r.rx_byte),
    .evt      (evt)
  );

  apfp_hold u_hold (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick_fire   (stage_fire && (in_data_r.operation == OP_TICK)),
    .elapsed_ms  (in_data_r.elapsed_ms),
    .evt         (evt),
    .position_nxt(position_nxt),
    .valid_nxt   (valid_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) in_valid_r <= 1'b1;
      else if (stage_fire) in_valid_r <= 1'b0;
      if (stage_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) in_data_r <= in_data;
    if (stage_fire) begin
      out_data_r.position       <= position_nxt;
      out_data_r.position_valid <= valid_nxt;
      out_data_r.frame_accepted <= evt.good;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("input stalled while a register was free");

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    stage_fire |=> out_valid_r)
    else $error("request left the input register but no result appeared");

  a_accept_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_accepted) |-> out_data_r.position_valid)
    else $error("good frame reported without a valid position");

  a_tick_never_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && (in_data_r.operation == OP_TICK)) |=> !out_data_r.frame_accepted)
    else $error("tick request reported a completed frame");

endmodule

>>> hw/rtl/apfp_parser.sv
// Byte-level frame parser: header check, sign, saturating digit accumulation.
// Depends on apfp_pkg.
module apfp_parser
  import apfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES     = FRAME_BYTES_DEF,
  parameter int unsigned MAX_DIGIT_VALUE = MAX_DIGIT_VALUE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_fire,
  input  logic [7:0] rx_byte,
  output apfp_evt_t  evt
);

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned DW = $clog2(MAX_DIGIT_VALUE + 1);
  localparam int unsigned VW = DW + 4;

  typedef enum logic [3:0] {
    PH_HDR    = 4'b0001,
    PH_COMMA  = 4'b0010,
    PH_SIGN   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  logic          active_r, active_nxt;
  logic [CW-1:0] count_r, count_nxt;
  phase_t        phase_r, phase_nxt;
  logic          neg_r, neg_nxt;
  logic [DW-1:0] digit_r, digit_nxt;
  logic          seen_r, seen_nxt;
  logic          bad_r, bad_nxt;

  logic                 is_digit;
  logic [3:0]           digit_in;
  logic [VW-1:0]        dig_ext;
  logic [VW-1:0]        dig_x10;
  logic [VW-1:0]        dig_sum;
  logic [DW-1:0]        dig_sat;
  logic [VW+POS_W-1:0]  mag_w;
  logic [POS_W-1:0]     mag;
  logic                 good;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit_in = 4'(rx_byte - CH_ZERO);
  assign dig_ext  = VW'(digit_r);
  assign dig_x10  = (dig_ext << 3) + (dig_ext << 1);
  assign dig_sum  = dig_x10 + VW'(digit_in);
  assign dig_sat  = (dig_sum > VW'(MAX_DIGIT_VALUE)) ? DW'(MAX_DIGIT_VALUE)
                                                     : dig_sum[DW-1:0];

  // The position wraps to the result width, so negating the truncated
  // magnitude gives the same bits as negating the full product.
  assign mag_w = {{POS_W{1'b0}}, dig_x10};
  assign mag   = mag_w[POS_W-1:0];

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    digit_nxt  = digit_r;
    seen_nxt   = seen_r;
    bad_nxt    = bad_r;
    good       = 1'b0;

    if (rx_byte == CH_DOLLAR) begin
      active_nxt = 1'b1;
      count_nxt  = CW'(1);
      phase_nxt  = PH_HDR;
      neg_nxt    = 1'b0;
      digit_nxt  = '0;
      seen_nxt   = 1'b0;
      bad_nxt    = 1'b0;
    end else if (active_r) begin
      if (count_r >= CW'(FRAME_BYTES)) begin
        active_nxt = 1'b0;
        count_nxt  = '0;
      end else if (rx_byte == CH_HASH) begin
        good       = !bad_r && (phase_r == PH_DIGITS) && seen_r;
        active_nxt = 1'b0;
        count_nxt  = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        if (!bad_r) begin
          unique case (phase_r)
            PH_HDR: begin
              if (rx_byte == CH_B) phase_nxt = PH_COMMA;
              else bad_nxt = 1'b1;
            end
            PH_COMMA: begin
              if (rx_byte == CH_COMMA) phase_nxt = PH_SIGN;
              else bad_nxt = 1'b1;
            end
            PH_SIGN: begin
              phase_nxt = PH_DIGITS;
              if (rx_byte == CH_MINUS) begin
                neg_nxt = 1'b1;
              end else if (rx_byte == CH_PLUS) begin
                neg_nxt = neg_r;
              end else if (is_digit) begin
                digit_nxt = dig_sat;
                seen_nxt  = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                digit_nxt = dig_sat;
                seen_nxt  = 1'b1;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            default: bad_nxt = 1'b1;
          endcase
        end
      end
    end
  end

  assign evt.good     = byte_fire && good;
  assign evt.position = neg_r ? $signed(-mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      phase_r  <= PH_HDR;
      neg_r    <= 1'b0;
      digit_r  <= '0;
      seen_r   <= 1'b0;
      bad_r    <= 1'b0;
    end else if (byte_fire) begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      digit_r  <= digit_nxt;
      seen_r   <= seen_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

>>> hw/rtl/apfp_hold.sv
// Held position, valid flag, elapsed timer and the timeout limit register.
// Depends on apfp_pkg.
module apfp_hold
  import apfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [TIMER_W-1:0]      cfg_wr_data,
  input  logic                    tick_fire,
  input  logic [TIMER_W-1:0]      elapsed_ms,
  input  apfp_evt_t               evt,
  output logic signed [POS_W-1:0] position_nxt,
  output logic                    valid_nxt
);

  logic [TIMER_W-1:0]      limit_r;
  logic [TIMER_W-1:0]      elapsed_r, elapsed_nxt;
  logic signed [POS_W-1:0] position_r;
  logic                    valid_r;
  logic [TIMER_W-1:0]      elapsed_add;

  // The sum is taken only when it stays below the timer ceiling.
  always_comb begin
    elapsed_add = elapsed_r;
    if (elapsed_r < (TIMER_MAX - elapsed_ms)) elapsed_add = elapsed_r + elapsed_ms;
  end

  always_comb begin
    elapsed_nxt  = elapsed_r;
    position_nxt = position_r;
    valid_nxt    = valid_r;
    if (evt.good) begin
      elapsed_nxt  = '0;
      position_nxt = evt.position;
      valid_nxt    = 1'b1;
    end else if (tick_fire) begin
      elapsed_nxt = elapsed_add;
      if (elapsed_add > limit_r) begin
        elapsed_nxt = limit_r;
        valid_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= TIMEOUT_RESET;
      elapsed_r  <= '0;
      position_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      elapsed_r  <= elapsed_nxt;
      position_r <= position_nxt;
      valid_r    <= valid_nxt;
    end
  end

endmodule
